[rtl/cmmd_pkg.sv]
// Shared types, codes and address map constants for the bus access decoder.
package cmmd_pkg;

    localparam int unsigned AddrW   = 32;
    localparam int unsigned DataW   = 32;
    localparam int unsigned OffsetW = 21;
    localparam int unsigned PageW   = 16;

    localparam logic [AddrW-1:0] CtrlAddr  = 32'hfffe_0130;
    localparam logic [DataW-1:0] CodeIsoA  = 32'h0000_0800;
    localparam logic [DataW-1:0] CodeIsoB  = 32'h0000_0804;
    localparam logic [DataW-1:0] CodeOpen  = 32'h0001_e988;

    localparam logic [PageW-1:0] PagePio     = 16'h1f00;
    localparam logic [PageW-1:0] PageScratch = 16'h1f80;
    localparam logic [15:0]      ScratchTop  = 16'h1000;

    // Main RAM windows, compared on page bits 15:7.
    localparam logic [8:0] RamWin0 = 9'h000;
    localparam logic [8:0] RamWin1 = 9'h100;
    localparam logic [8:0] RamWin2 = 9'h140;

    // Boot ROM pages 0xbfc0 to 0xbfc7, compared on page bits 15:3.
    localparam logic [12:0] RomBase = 13'h17f8;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2,
        SIZE_RSVD = 2'd3
    } t_size;

    typedef enum logic [2:0] {
        REGION_RAM     = 3'd0,
        REGION_PIO     = 3'd1,
        REGION_SCRATCH = 3'd2,
        REGION_ROM     = 3'd3,
        REGION_HW      = 3'd4,
        REGION_NONE    = 3'd5
    } t_region;

    typedef struct packed {
        logic             cmd;
        t_size            access_size;
        logic [AddrW-1:0] address;
        logic [DataW-1:0] write_data;
    } t_access;

    typedef struct packed {
        t_region            region;
        logic [OffsetW-1:0] local_offset;
        logic               is_write;
        t_size              size_out;
        logic [DataW-1:0]   data_out;
        logic               write_dropped;
    } t_result;

    typedef struct packed {
        logic hit;
        logic isolate;
        logic open;
    } t_iso_ctrl;

endpackage

[rtl/cmmd_decode.sv]
// Combinational address decode of one access and detection of isolate control writes.
module cmmd_decode (
    input  cmmd_pkg::t_access   i_access,
    input  logic                i_ram_we,
    output cmmd_pkg::t_result   o_result,
    output cmmd_pkg::t_iso_ctrl o_iso
);

    logic [cmmd_pkg::PageW-1:0] page;
    logic [15:0]                poff;
    logic                       is_wr;

    assign page  = i_access.address[31:16];
    assign poff  = i_access.address[15:0];
    assign is_wr = i_access.cmd;

    always_comb begin
        o_result.is_write      = is_wr;
        o_result.size_out      = i_access.access_size;
        o_result.data_out      = is_wr ? i_access.write_data : '0;
        o_result.write_dropped = 1'b0;
        o_result.local_offset  = {5'd0, poff};
        if (page[15:7] inside {cmmd_pkg::RamWin0, cmmd_pkg::RamWin1, cmmd_pkg::RamWin2}) begin
            o_result.region        = cmmd_pkg::REGION_RAM;
            o_result.local_offset  = {page[4:0], poff};
            o_result.write_dropped = is_wr & ~i_ram_we;
        end else if (page == cmmd_pkg::PagePio) begin
            o_result.region = cmmd_pkg::REGION_PIO;
        end else if (page == cmmd_pkg::PageScratch) begin
            o_result.region = (poff < cmmd_pkg::ScratchTop) ? cmmd_pkg::REGION_SCRATCH
                                                            : cmmd_pkg::REGION_HW;
        end else if (page[15:3] == cmmd_pkg::RomBase) begin
            o_result.region        = cmmd_pkg::REGION_ROM;
            o_result.local_offset  = {2'd0, page[2:0], poff};
            o_result.write_dropped = is_wr;
        end else begin
            o_result.region        = cmmd_pkg::REGION_NONE;
            o_result.local_offset  = '0;
            o_result.write_dropped = is_wr;
        end
    end

    always_comb begin
        o_iso.hit     = is_wr && (i_access.access_size == cmmd_pkg::SIZE_WORD)
                        && (i_access.address == cmmd_pkg::CtrlAddr);
        o_iso.isolate = o_iso.hit && ((i_access.write_data == cmmd_pkg::CodeIsoA)
                        || (i_access.write_data == cmmd_pkg::CodeIsoB));
        o_iso.open    = o_iso.hit && (i_access.write_data == cmmd_pkg::CodeOpen);
    end

endmodule

[rtl/console_memory_map_decoder.sv]
// Top level of the bus access decoder: input register, decode, result register.
// An access in the input register is decoded and its result captured in the output register.
// Throughput is one access per cycle unless the sink stalls the output register;
// the input register refills as the result register drains.
// The RAM write-enable bit changes as the control write passes decode and applies to the next access.
// Synchronous active-low reset empties both registers and sets the RAM write-enable bit.
module console_memory_map_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // address[31:0], write_data[63:32]
    input  logic [2:0]  s_axis_tuser,  // cmd[0], access_size[2:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // local_offset[20:0], data_out[52:21], zero pad[55:53]
    output logic [6:0]  m_axis_tuser   // region[2:0], is_write[3], size_out[5:4], write_dropped[6]
);

    logic                r_in_valid;
    cmmd_pkg::t_access   r_in;
    logic                r_out_valid;
    cmmd_pkg::t_result   r_out;
    logic                r_ram_we;
    logic                n_ram_we;
    logic                advance;
    cmmd_pkg::t_result   dec_result;
    cmmd_pkg::t_iso_ctrl dec_iso;

    assign advance       = ~r_out_valid | m_axis_tready;
    assign s_axis_tready = ~r_in_valid | advance;

    cmmd_decode u_decode (
        .i_access (r_in),
        .i_ram_we (r_ram_we),
        .o_result (dec_result),
        .o_iso    (dec_iso)
    );

    always_comb begin
        n_ram_we = r_ram_we;
        if (r_in_valid && advance) begin
            if (dec_iso.isolate) begin
                n_ram_we = 1'b0;
            end else if (dec_iso.open) begin
                n_ram_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ram_we    <= 1'b1;
        end else begin
            r_ram_we <= n_ram_we;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.cmd         <= s_axis_tuser[0];
            r_in.access_size <= cmmd_pkg::t_size'(s_axis_tuser[2:1]);
            r_in.address     <= s_axis_tdata[31:0];
            r_in.write_data  <= s_axis_tdata[63:32];
        end
        if (advance && r_in_valid) begin
            r_out <= dec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.data_out, r_out.local_offset};
    assign m_axis_tuser  = {r_out.write_dropped, r_out.size_out, r_out.is_write, r_out.region};

    a_drop_only_on_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[6] |-> m_axis_tuser[3])
        else $error("Dropped flag set on a read result.");

    a_read_data_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[3] |-> (m_axis_tdata[52:21] == '0))
        else $error("Read result carries non-zero data.");

    a_isolate_takes_effect : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance && dec_iso.isolate |=> !r_ram_we)
        else $error("Isolate control transfer did not clear the RAM write enable.");

    a_ctrl_write_unmapped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance && dec_iso.hit |=> m_axis_tvalid
        && (m_axis_tuser[2:0] == cmmd_pkg::REGION_NONE) && m_axis_tuser[6])
        else $error("Isolate control write not reported as an unmapped drop.");

endmodule

[tb/access_route_checker.sv]
// Checker for the bus access decoder: predicts each routed access and compares it on the output.
module access_route_checker
    import cmmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    input  logic [63:0] i_in_tdata,   // address[31:0], write_data[63:32]
    input  logic [2:0]  i_in_tuser,   // cmd[0], access_size[2:1]
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    input  logic [55:0] i_out_tdata,  // local_offset[20:0], data_out[52:21], zero pad[55:53]
    input  logic [6:0]  i_out_tuser,  // region[2:0], is_write[3], size_out[5:4], write_dropped[6]
    output int          o_errors,
    output int          o_pending
);

    t_result routed_q[$];
    logic    ram_writable;

    function automatic t_result route_access(t_access a, logic writable);
        t_result     r;
        logic [15:0] page;
        logic [15:0] poff;
        page            = a.address[31:16];
        poff            = a.address[15:0];
        r.is_write      = a.cmd;
        r.size_out      = a.access_size;
        r.data_out      = a.cmd ? a.write_data : '0;
        r.write_dropped = 1'b0;
        r.local_offset  = 21'(poff);
        if (page < 16'h0080 || (page >= 16'h8000 && page < 16'h8080) ||
            (page >= 16'ha000 && page < 16'ha080)) begin
            r.region        = REGION_RAM;
            r.local_offset  = {page[4:0], poff};
            r.write_dropped = a.cmd && !writable;
        end else if (page == 16'h1f00) begin
            r.region = REGION_PIO;
        end else if (page == 16'h1f80) begin
            r.region = (poff < 16'h1000) ? REGION_SCRATCH : REGION_HW;
        end else if (page >= 16'hbfc0 && page <= 16'hbfc7) begin
            r.region        = REGION_ROM;
            r.local_offset  = 21'({page[2:0], poff});
            r.write_dropped = a.cmd;
        end else begin
            r.region        = REGION_NONE;
            r.local_offset  = '0;
            r.write_dropped = a.cmd;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            o_errors++;
        end
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_access acc;
        t_result want;
        if (!i_rst_n) begin
            routed_q.delete();
            ram_writable = 1'b1;
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (routed_q.size() == 0) begin
                    $display("%0t: result transfer with no access outstanding, got 0x%0h/0x%0h",
                             $time, i_out_tuser, i_out_tdata);
                    o_errors++;
                end else begin
                    want = routed_q.pop_front();
                    check_field("region", 32'(want.region), 32'(i_out_tuser[2:0]));
                    check_field("local_offset", 32'(want.local_offset), 32'(i_out_tdata[20:0]));
                    check_field("is_write", 32'(want.is_write), 32'(i_out_tuser[3]));
                    check_field("size_out", 32'(want.size_out), 32'(i_out_tuser[5:4]));
                    check_field("data_out", want.data_out, i_out_tdata[52:21]);
                    check_field("write_dropped", 32'(want.write_dropped), 32'(i_out_tuser[6]));
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                acc.cmd         = i_in_tuser[0];
                acc.access_size = t_size'(i_in_tuser[2:1]);
                acc.address     = i_in_tdata[31:0];
                acc.write_data  = i_in_tdata[63:32];
                routed_q.push_back(route_access(acc, ram_writable));
                if (acc.cmd && acc.access_size == SIZE_WORD && acc.address == CtrlAddr) begin
                    if (acc.write_data == CodeIsoA || acc.write_data == CodeIsoB) begin
                        ram_writable = 1'b0;
                    end else if (acc.write_data == CodeOpen) begin
                        ram_writable = 1'b1;
                    end
                end
            end
        end
        o_pending = routed_q.size();
    end

endmodule

[tb/testbench.sv]
// Top of the bus access decoder testbench: clock, reset, access stimulus, sink pacing and verdict.
module testbench;
    import cmmd_pkg::*;

    localparam int   CycleLimit     = 1_000_000;
    localparam int   RandomAccesses = 1850;
    localparam int   DrainPause     = 8;
    localparam logic CmdRead        = 1'b0;
    localparam logic CmdWrite       = 1'b1;

    localparam logic [15:0] EdgePages [12] = '{
        16'h0080, 16'h7fff, 16'h8080, 16'h9fff, 16'ha080, 16'hbfbf,
        16'hbfc8, 16'h1eff, 16'h1f01, 16'h1f7f, 16'h1f81, 16'hffff
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;  // address[31:0], write_data[63:32]
    logic [2:0]  s_axis_tuser  = '0;  // cmd[0], access_size[2:1]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // local_offset[20:0], data_out[52:21], zero pad[55:53]
    logic [6:0]  m_axis_tuser;        // region[2:0], is_write[3], size_out[5:4], write_dropped[6]

    int errors;
    int pending;
    int cycle_count = 0;
    int sink_stall  = 0;
    bit sink_steady = 1'b0;
    bit feed_steady = 1'b0;

    console_memory_map_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    access_route_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("testbench: errors");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) begin
            sink_steady = !sink_steady;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall--;
        end else begin
            m_axis_tready <= 1'b1;
            sink_stall = sink_steady ? 0 : pick_gap();
        end
    end

    task automatic send_access(logic cmd, t_size size, logic [31:0] addr, logic [31:0] data);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= {size, cmd};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        if ($urandom_range(0, 149) == 0) begin
            feed_steady = !feed_steady;
        end
        gap = feed_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_access random_access();
        t_access     a;
        logic [15:0] page;
        logic [15:0] poff;
        a.cmd         = 1'($urandom_range(0, 1));
        a.access_size = ($urandom_range(0, 9) == 0) ? SIZE_RSVD : t_size'($urandom_range(0, 2));
        a.write_data  = $urandom();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
                0:       a.write_data = CodeIsoA;
                1:       a.write_data = CodeIsoB;
                default: a.write_data = CodeOpen;
            endcase
        end
        poff = 16'($urandom_range(0, 16'hffff));
        case ($urandom_range(0, 15))
            0, 1, 2, 3: begin
                case ($urandom_range(0, 2))
                    0:       page = 16'h0000;
                    1:       page = 16'h8000;
                    default: page = 16'ha000;
                endcase
                page = page + 16'($urandom_range(0, 127));
            end
            4: page = PagePio;
            5: begin
                page = PageScratch;
                poff = 16'($urandom_range(0, 16'h0fff));
            end
            6: begin
                page = PageScratch;
                poff = 16'($urandom_range(16'h1000, 16'hffff));
            end
            7: page = 16'hbfc0 + 16'($urandom_range(0, 7));
            8: page = EdgePages[4'($urandom_range(0, 11))];
            9, 10: begin
                page = CtrlAddr[31:16];
                poff = CtrlAddr[15:0];
                if ($urandom_range(0, 5) == 0) begin
                    {page, poff} = CtrlAddr ^ (32'd1 << $urandom_range(0, 31));
                end
                a.cmd = ($urandom_range(0, 5) != 0) ? CmdWrite : CmdRead;
                if ($urandom_range(0, 4) != 0) begin
                    a.access_size = SIZE_WORD;
                end
                case ($urandom_range(0, 3))
                    0:       a.write_data = CodeIsoA;
                    1:       a.write_data = CodeIsoB;
                    2:       a.write_data = CodeOpen;
                    default: a.write_data = $urandom();
                endcase
            end
            default: {page, poff} = $urandom();
        endcase
        a.address = {page, poff};
        return a;
    endfunction

    initial begin
        t_access acc;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_access(CmdRead,  SIZE_BYTE, 32'h0000_0000, 32'hffff_ffff);
        send_access(CmdWrite, SIZE_WORD, 32'h001f_fffc, 32'hffff_ffff);
        send_access(CmdRead,  SIZE_HALF, 32'h807f_fffe, 32'h0000_0000);
        send_access(CmdWrite, SIZE_BYTE, 32'ha000_0000, 32'h0000_0000);
        send_access(CmdRead,  SIZE_WORD, 32'h0080_0000, 32'h1234_5678);
        send_access(CmdWrite, SIZE_WORD, 32'h9fff_ffff, 32'h5a5a_a5a5);
        send_access(CmdWrite, SIZE_HALF, 32'h1f00_ffff, 32'h0000_ffff);
        send_access(CmdRead,  SIZE_BYTE, 32'h1f80_0fff, 32'h0000_0000);
        send_access(CmdWrite, SIZE_WORD, 32'h1f80_1000, 32'hdead_beef);
        send_access(CmdRead,  SIZE_BYTE, 32'hbfc0_0000, 32'h0000_0000);
        send_access(CmdWrite, SIZE_WORD, 32'hbfc7_ffff, 32'hcafe_f00d);
        send_access(CmdRead,  SIZE_WORD, 32'hbfc8_0000, 32'h0000_0000);
        // Isolate RAM, then show that only RAM writes are refused.
        send_access(CmdWrite, SIZE_WORD, CtrlAddr, CodeIsoA);
        send_access(CmdWrite, SIZE_WORD, 32'h0000_1000, 32'h1111_1111);
        send_access(CmdRead,  SIZE_WORD, 32'ha07f_0000, 32'h0000_0000);
        send_access(CmdWrite, SIZE_BYTE, 32'h1f80_0000, 32'h2222_2222);
        // Neither the reserved size, a halfword nor a wrong code may reopen RAM.
        send_access(CmdWrite, SIZE_RSVD, CtrlAddr, CodeOpen);
        send_access(CmdWrite, SIZE_HALF, CtrlAddr, CodeOpen);
        send_access(CmdWrite, SIZE_WORD, CtrlAddr, CodeOpen + 32'd1);
        send_access(CmdWrite, SIZE_WORD, 32'h8000_0000, 32'h3333_3333);
        send_access(CmdWrite, SIZE_WORD, CtrlAddr, CodeOpen);
        send_access(CmdWrite, SIZE_HALF, 32'h8001_0002, 32'h4444_4444);
        send_access(CmdWrite, SIZE_WORD, CtrlAddr, CodeIsoB);
        send_access(CmdRead,  SIZE_WORD, CtrlAddr, 32'h0000_0000);
        send_access(CmdRead,  SIZE_RSVD, 32'hffff_ffff, 32'hffff_ffff);

        repeat (RandomAccesses) begin
            acc = random_access();
            send_access(acc.cmd, acc.access_size, acc.address, acc.write_data);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (DrainPause) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[console_memory_map_decoder.f]
rtl/cmmd_pkg.sv
rtl/cmmd_decode.sv
rtl/console_memory_map_decoder.sv
tb/access_route_checker.sv
tb/testbench.sv
